### rtl/core/udcp_pkg.sv
package udcp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned FIELD_W = 2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMAND = 8'h63;
  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

  // Field slots
  localparam logic [FIELD_W-1:0] FIELD_LEFT  = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_RIGHT = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_EXTRA = 2'd2;

  typedef struct packed {
    logic                      emit;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } result_t;

endpackage

### rtl/core/udcp_parse.sv
module udcp_parse #(
  parameter int unsigned MAX_LINE = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [udcp_pkg::BYTE_W-1:0] rx_byte,
  output udcp_pkg::result_t           res
);

  localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
  localparam int unsigned ACC_W = udcp_pkg::DRIVE_W + 5;

  logic [LEN_W-1:0]                   len_r, len_nxt;
  logic [udcp_pkg::BYTE_W-1:0]        hdr_r, hdr_nxt;
  logic [udcp_pkg::FIELD_W-1:0]       fn_r, fn_nxt;
  logic                               in_field_r, in_field_nxt;
  logic                               neg_r, neg_nxt;
  logic                               seen_r, seen_nxt;
  logic                               ended_r, ended_nxt;
  logic signed [udcp_pkg::DRIVE_W-1:0] left_r, left_nxt;
  logic signed [udcp_pkg::DRIVE_W-1:0] right_r, right_nxt;

  logic                               is_newline, is_digit, is_blank, is_sign;
  logic                               acc_neg;
  logic signed [udcp_pkg::DRIVE_W-1:0] acc_sel;
  logic signed [ACC_W-1:0]            acc_ext, acc_x10, acc_sum;
  logic signed [ACC_W-1:0]            digit_ext;
  logic signed [udcp_pkg::DRIVE_W-1:0] acc_new;

  assign is_newline = (rx_byte == udcp_pkg::CH_NEWLINE);
  assign is_digit   = (rx_byte >= udcp_pkg::CH_ZERO) && (rx_byte <= udcp_pkg::CH_NINE);
  assign is_blank   = (rx_byte == udcp_pkg::CH_SPACE) ||
                      ((rx_byte >= udcp_pkg::CH_TAB) && (rx_byte <= udcp_pkg::CH_CR));
  assign is_sign    = (rx_byte == udcp_pkg::CH_PLUS) || (rx_byte == udcp_pkg::CH_MINUS);

  // Result for a newline that closes a command line
  assign res.emit        = is_newline && (len_r != '0) && (hdr_r == udcp_pkg::CH_COMMAND);
  assign res.left_drive  = left_r;
  assign res.right_drive = right_r;

  // Multiply-accumulate one decimal digit with clamp; sign is the field's
  // sign as of this byte (a fresh field starts positive)
  assign acc_neg   = in_field_r ? neg_r : 1'b0;
  assign acc_sel   = (fn_r == udcp_pkg::FIELD_LEFT) ? left_r : right_r;
  assign acc_ext   = ACC_W'(acc_sel);
  assign acc_x10   = (acc_ext <<< 3) + (acc_ext <<< 1);
  assign digit_ext = ACC_W'($unsigned(rx_byte - udcp_pkg::CH_ZERO) & 8'h0F);
  assign acc_sum   = acc_neg ? (acc_x10 - digit_ext) : (acc_x10 + digit_ext);

  always_comb begin
    if (acc_sum > ACC_W'(32767)) begin
      acc_new = 16'sh7FFF;
    end else if (acc_sum < -ACC_W'(32768)) begin
      acc_new = 16'sh8000;
    end else begin
      acc_new = acc_sum[udcp_pkg::DRIVE_W-1:0];
    end
  end

  always_comb begin
    logic sn, ss, de, do_acc;
    sn           = neg_r;
    ss           = seen_r;
    de           = ended_r;
    do_acc       = 1'b0;
    len_nxt      = len_r;
    hdr_nxt      = hdr_r;
    fn_nxt       = fn_r;
    in_field_nxt = in_field_r;
    neg_nxt      = neg_r;
    seen_nxt     = seen_r;
    ended_nxt    = ended_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    if (take) begin
      if (is_newline) begin
        len_nxt      = '0;
        hdr_nxt      = '0;
        fn_nxt       = udcp_pkg::FIELD_LEFT;
        in_field_nxt = 1'b0;
        neg_nxt      = 1'b0;
        seen_nxt     = 1'b0;
        ended_nxt    = 1'b0;
        left_nxt     = '0;
        right_nxt    = '0;
      end else if (len_r < LEN_W'(MAX_LINE)) begin
        len_nxt = len_r + LEN_W'(1);
        if (len_r == '0) begin
          hdr_nxt = rx_byte;
        end else if (rx_byte == udcp_pkg::CH_COMMA) begin
          if (in_field_r) begin
            in_field_nxt = 1'b0;
            if (fn_r != udcp_pkg::FIELD_EXTRA) begin
              fn_nxt = fn_r + udcp_pkg::FIELD_W'(1);
            end
          end
        end else begin
          if (!in_field_r) begin
            in_field_nxt = 1'b1;
            sn = 1'b0;
            ss = 1'b0;
            de = 1'b0;
          end
          if ((fn_r != udcp_pkg::FIELD_EXTRA) && !de) begin
            if (!ss) begin
              if (is_blank) begin
                ss = 1'b0;
              end else if (is_sign) begin
                ss = 1'b1;
                sn = (rx_byte == udcp_pkg::CH_MINUS);
              end else if (!is_digit) begin
                de = 1'b1;
              end else begin
                ss     = 1'b1;
                do_acc = 1'b1;
              end
            end else if (!is_digit) begin
              de = 1'b1;
            end else begin
              do_acc = 1'b1;
            end
          end
          neg_nxt   = sn;
          seen_nxt  = ss;
          ended_nxt = de;
          if (do_acc) begin
            if (fn_r == udcp_pkg::FIELD_LEFT) begin
              left_nxt = acc_new;
            end else begin
              right_nxt = acc_new;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      hdr_r      <= '0;
      fn_r       <= udcp_pkg::FIELD_LEFT;
      in_field_r <= 1'b0;
      neg_r      <= 1'b0;
      seen_r     <= 1'b0;
      ended_r    <= 1'b0;
      left_r     <= '0;
      right_r    <= '0;
    end else begin
      len_r      <= len_nxt;
      hdr_r      <= hdr_nxt;
      fn_r       <= fn_nxt;
      in_field_r <= in_field_nxt;
      neg_r      <= neg_nxt;
      seen_r     <= seen_nxt;
      ended_r    <= ended_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
    end
  end

endmodule

### rtl/core/uart_drive_command_parser_top.sv
// Path: a byte transfer on the input lands in the input register; when the parser takes
//   it, a command result is loaded into the output register.
// Throughput: one byte per cycle unless a result meets a full, stalled output register;
//   parse and multiply-by-ten between the input and result registers are combinational.
// Reset: synchronous, active low; clears the line parse state and both valid flags.
module uart_drive_command_parser_top #(
  parameter int unsigned MAX_LINE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] left_drive, [31:16] right_drive
);

  logic                        in_v_r;
  logic [udcp_pkg::BYTE_W-1:0] in_byte_r;
  logic                        out_v_r;
  logic [31:0]                 out_data_r;
  logic                        take;
  logic                        in_xfer;
  udcp_pkg::result_t           res;

  // Parse the held byte unless it would produce a result that the full,
  // stalled output register cannot take.
  assign take      = in_v_r && (!res.emit || !out_v_r || out_tready);
  assign in_tready = !in_v_r || take;
  assign in_xfer   = in_tvalid && in_tready;

  udcp_parse #(
    .MAX_LINE (MAX_LINE)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  // Input register: hold the byte until the parser consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_xfer) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
    if (in_xfer) begin
      in_byte_r <= in_tdata;
    end
  end

  // Result register: load on a command newline, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take && res.emit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (take && res.emit) begin
      out_data_r <= {res.right_drive, res.left_drive};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule
